/* rtl/core/dws_pkg.sv */
// Package for the double-ended queue with search: sizes, request and status codes.
package dws_pkg;

	// Ring store depth and the widths that follow from it.
	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	// Fixed widths of the word fields.
	localparam int REQ_W  = 3;
	localparam int DATA_W = 32;
	localparam int STAT_W = 2;
	localparam int OUT_W  = 5;

	typedef logic [REQ_W-1:0]  req_t;
	typedef logic [STAT_W-1:0] stat_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	localparam req_t REQ_PUSH_BACK  = 3'd0;
	localparam req_t REQ_PUSH_FRONT = 3'd1;
	localparam req_t REQ_POP_FRONT  = 3'd2;
	localparam req_t REQ_POP_BACK   = 3'd3;
	localparam req_t REQ_SEARCH     = 3'd4;

	localparam stat_t ST_OK    = 2'd0;
	localparam stat_t ST_FULL  = 2'd1;
	localparam stat_t ST_EMPTY = 2'd2;

endpackage

/* rtl/core/deque_with_search_unit.sv */
// Top level of the double-ended queue with search: sequencer, ring store and compare unit.
//
// Usage: a request word (req_type, value) is accepted at a rising clock edge where
// start is high and busy is low. Busy then stays high until the request is finished.
// Every request gives exactly one result word on status, popped_value, found,
// match_count and occupancy, shown for exactly one cycle while done is high. The
// receiver cannot stall: it must take the word in that cycle. Busy falls in the same
// cycle that done rises, so a new start may be accepted while the result is shown.
//
// Every request passes through the execute state. A push, an unused request code or a pop
// on an empty queue finishes there; any other pop goes on to a state that takes the read
// entry, and a search goes on to the scan state. The search length is set by the single
// read port of the ring store: one held entry is read per cycle and checked in the cycle
// after by one shared 32-bit equality compare, and the count closes once the last check
// is done, so a search grows with the number of held entries.
//
// Reset (arst_n low, asynchronous) empties the queue: front index and count clear,
// the sequencer returns to idle and done is low. The ring store itself is not
// cleared; only slots that a push has written are ever read.
module deque_with_search_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [dws_pkg::REQ_W-1:0]         req_type,
	input  logic signed [dws_pkg::DATA_W-1:0] value,
	output logic                              done,
	output logic [dws_pkg::STAT_W-1:0]        status,
	output logic signed [dws_pkg::DATA_W-1:0] popped_value,
	output logic                              found,
	output logic [dws_pkg::OUT_W-1:0]         match_count,
	output logic [dws_pkg::OUT_W-1:0]         occupancy
);

	// Sequencer state codes.
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EXEC   = 3'd1;
	localparam logic [2:0] S_POP    = 3'd2;
	localparam logic [2:0] S_SEARCH = 3'd3;

	localparam int SUM_W = dws_pkg::CNT_W + 1;

	// Maps a front-relative sum below twice the depth back into the ring.
	function automatic dws_pkg::idx_t wrap(input logic [SUM_W-1:0] s);
		logic [SUM_W-1:0] r;
		begin
			r = s;
			if (s >= SUM_W'(dws_pkg::DEPTH)) begin
				r = s - SUM_W'(dws_pkg::DEPTH);
			end
			wrap = r[dws_pkg::IDX_W-1:0];
		end
	endfunction

	logic [2:0]                  state_q;
	dws_pkg::req_t               req_q;
	logic [dws_pkg::DATA_W-1:0]  val_q;
	dws_pkg::idx_t               front_q;
	dws_pkg::cnt_t               cnt_q;
	dws_pkg::cnt_t               idx_q;
	dws_pkg::cnt_t               matches_q;
	logic                        pend_q;

	logic                        done_q;
	dws_pkg::stat_t              status_q;
	logic [dws_pkg::DATA_W-1:0]  popped_q;
	logic                        found_q;
	logic [dws_pkg::OUT_W-1:0]   match_q;
	logic [dws_pkg::OUT_W-1:0]   occ_q;

	// Ring store: one write and one registered read per cycle.
	logic [dws_pkg::DATA_W-1:0]  mem [dws_pkg::DEPTH];
	logic [dws_pkg::DATA_W-1:0]  rd_q;
	logic                        we;
	dws_pkg::idx_t               wa;
	dws_pkg::idx_t               ra;

	logic                        accept;
	logic                        full;
	logic                        empty;
	logic                        hit;
	dws_pkg::idx_t               back_pos;
	dws_pkg::idx_t               tail_pos;
	dws_pkg::idx_t               front_dec;
	dws_pkg::idx_t               front_inc;
	dws_pkg::idx_t               scan_pos;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign full   = (cnt_q == dws_pkg::CNT_W'(dws_pkg::DEPTH));
	assign empty  = (cnt_q == '0);

	// The one shared compare unit: the entry read last cycle against the search value.
	assign hit = (rd_q == val_q);

	// Slot after the back (push back target) and the back slot itself (pop back).
	assign tail_pos  = wrap(SUM_W'(front_q) + SUM_W'(cnt_q));
	assign back_pos  = wrap(SUM_W'(front_q) + SUM_W'(cnt_q) - SUM_W'(1));
	assign scan_pos  = wrap(SUM_W'(front_q) + SUM_W'(idx_q));
	assign front_dec = (front_q == '0) ? dws_pkg::IDX_W'(dws_pkg::DEPTH - 1)
	                                   : front_q - dws_pkg::IDX_W'(1);
	assign front_inc = (front_q == dws_pkg::IDX_W'(dws_pkg::DEPTH - 1)) ? '0
	                                   : front_q + dws_pkg::IDX_W'(1);

	// Store port control.
	always_comb begin
		we = 1'b0;
		wa = tail_pos;
		ra = front_q;
		if (state_q == S_EXEC) begin
			case (req_q)
				dws_pkg::REQ_PUSH_BACK: begin
					we = !full;
					wa = tail_pos;
				end
				dws_pkg::REQ_PUSH_FRONT: begin
					we = !full;
					wa = front_dec;
				end
				dws_pkg::REQ_POP_BACK: begin
					ra = back_pos;
				end
				default: begin
					ra = front_q;
				end
			endcase
		end else if (state_q == S_SEARCH) begin
			ra = scan_pos;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= val_q;
		end
		rd_q <= mem[ra];
	end

	// Sequencer and queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			front_q   <= '0;
			cnt_q     <= '0;
			idx_q     <= '0;
			matches_q <= '0;
			pend_q    <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (req_q)
						dws_pkg::REQ_PUSH_BACK: begin
							if (!full) begin
								cnt_q <= cnt_q + dws_pkg::CNT_W'(1);
							end
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end
						dws_pkg::REQ_PUSH_FRONT: begin
							if (!full) begin
								cnt_q   <= cnt_q + dws_pkg::CNT_W'(1);
								front_q <= front_dec;
							end
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end
						dws_pkg::REQ_POP_FRONT: begin
							if (empty) begin
								state_q <= S_IDLE;
								done_q  <= 1'b1;
							end else begin
								cnt_q   <= cnt_q - dws_pkg::CNT_W'(1);
								front_q <= front_inc;
								state_q <= S_POP;
							end
						end
						dws_pkg::REQ_POP_BACK: begin
							if (empty) begin
								state_q <= S_IDLE;
								done_q  <= 1'b1;
							end else begin
								cnt_q   <= cnt_q - dws_pkg::CNT_W'(1);
								state_q <= S_POP;
							end
						end
						dws_pkg::REQ_SEARCH: begin
							idx_q     <= '0;
							matches_q <= '0;
							pend_q    <= 1'b0;
							state_q   <= S_SEARCH;
						end
						default: begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end
					endcase
				end
				S_POP: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				S_SEARCH: begin
					// Issue one read per cycle; the compare checks each read once its registered data is back.
					if (idx_q != cnt_q) begin
						idx_q  <= idx_q + dws_pkg::CNT_W'(1);
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
					end
					if (pend_q && hit) begin
						matches_q <= matches_q + dws_pkg::CNT_W'(1);
					end
					if ((idx_q == cnt_q) && !pend_q) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request word capture and result word registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_type;
			val_q <= value;
		end
		case (state_q)
			S_EXEC: begin
				status_q <= dws_pkg::ST_OK;
				popped_q <= '0;
				found_q  <= 1'b0;
				match_q  <= '0;
				occ_q    <= dws_pkg::OUT_W'(cnt_q);
				if (req_q inside {dws_pkg::REQ_PUSH_BACK, dws_pkg::REQ_PUSH_FRONT}) begin
					if (full) begin
						status_q <= dws_pkg::ST_FULL;
					end else begin
						occ_q <= dws_pkg::OUT_W'(cnt_q + dws_pkg::CNT_W'(1));
					end
				end else if (req_q inside {dws_pkg::REQ_POP_FRONT, dws_pkg::REQ_POP_BACK}) begin
					if (empty) begin
						status_q <= dws_pkg::ST_EMPTY;
					end
				end
			end
			S_POP: begin
				// The count was already lowered when the read was issued.
				popped_q <= rd_q;
				occ_q    <= dws_pkg::OUT_W'(cnt_q);
			end
			S_SEARCH: begin
				if ((idx_q == cnt_q) && !pend_q) begin
					found_q <= (matches_q != '0);
					match_q <= dws_pkg::OUT_W'(matches_q);
					occ_q   <= dws_pkg::OUT_W'(cnt_q);
				end
			end
			default: begin
				occ_q <= occ_q;
			end
		endcase
	end

	assign done         = done_q;
	assign status       = status_q;
	assign popped_value = popped_q;
	assign found        = found_q;
	assign match_count  = match_q;
	assign occupancy    = occ_q;

	// A result word only appears as the sequencer returns to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE))
		else $error("result word shown while the sequencer is still working");

	// The held count never passes the store depth.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= dws_pkg::CNT_W'(dws_pkg::DEPTH))
		else $error("entry count above depth");

	// An accepted request word always makes the unit busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("request word accepted without going busy");

	// A refused push is only reported when the queue is really full.
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (status_q == dws_pkg::ST_FULL)) |-> full)
		else $error("full status reported on a queue that is not full");

	// Search scan index never runs past the held count.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH) |-> (idx_q <= cnt_q))
		else $error("search index past the held entries");

endmodule

/* test/dws_checker.sv */
`timescale 1ns / 1ps
// Checker for the double-ended queue with search: predicts each result word and compares it.
module dws_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  logic [dws_pkg::REQ_W-1:0]         req_type,
	input  logic signed [dws_pkg::DATA_W-1:0] value,
	input  logic                              done,
	input  logic [dws_pkg::STAT_W-1:0]        status,
	input  logic signed [dws_pkg::DATA_W-1:0] popped_value,
	input  logic                              found,
	input  logic [dws_pkg::OUT_W-1:0]         match_count,
	input  logic [dws_pkg::OUT_W-1:0]         occupancy,
	output int                                errors,
	output int                                outstanding
);

	typedef struct packed {
		dws_pkg::stat_t             status;
		logic [dws_pkg::DATA_W-1:0] popped;
		logic                       found;
		logic [dws_pkg::OUT_W-1:0]  hit_count;
		logic [dws_pkg::OUT_W-1:0]  held;
	} dq_result_t;

	// Shadow copy of the queue contents.
	logic [dws_pkg::DATA_W-1:0] ring [dws_pkg::DEPTH];
	int                         head_slot;
	int                         held_count;
	dq_result_t                 pending_results [$];
	int                         fail_count;

	function automatic dq_result_t apply_request(input dws_pkg::req_t kind,
			input logic [dws_pkg::DATA_W-1:0] operand);
		dq_result_t res;
		int         hits;
		hits = 0;
		res = '0;
		res.status = dws_pkg::ST_OK;
		case (kind)
			dws_pkg::REQ_PUSH_BACK: begin
				if (held_count == dws_pkg::DEPTH) begin
					res.status = dws_pkg::ST_FULL;
				end else begin
					ring[(head_slot + held_count) % dws_pkg::DEPTH] = operand;
					held_count++;
				end
			end
			dws_pkg::REQ_PUSH_FRONT: begin
				if (held_count == dws_pkg::DEPTH) begin
					res.status = dws_pkg::ST_FULL;
				end else begin
					head_slot = (head_slot + dws_pkg::DEPTH - 1) % dws_pkg::DEPTH;
					ring[head_slot] = operand;
					held_count++;
				end
			end
			dws_pkg::REQ_POP_FRONT: begin
				if (held_count == 0) begin
					res.status = dws_pkg::ST_EMPTY;
				end else begin
					res.popped = ring[head_slot];
					head_slot = (head_slot + 1) % dws_pkg::DEPTH;
					held_count--;
				end
			end
			dws_pkg::REQ_POP_BACK: begin
				if (held_count == 0) begin
					res.status = dws_pkg::ST_EMPTY;
				end else begin
					res.popped = ring[(head_slot + held_count - 1) % dws_pkg::DEPTH];
					held_count--;
				end
			end
			dws_pkg::REQ_SEARCH: begin
				for (int i = 0; i < held_count; i++) begin
					if (ring[(head_slot + i) % dws_pkg::DEPTH] == operand) hits++;
				end
			end
			default: begin
			end
		endcase
		res.hit_count = hits[dws_pkg::OUT_W-1:0];
		res.found = (hits != 0);
		res.held = held_count[dws_pkg::OUT_W-1:0];
		return res;
	endfunction

	task automatic report(input string field, input logic [dws_pkg::DATA_W-1:0] want,
			input logic [dws_pkg::DATA_W-1:0] got);
		fail_count++;
		$display("%0t: %s differs, expected %0h, actual %0h", $time, field, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		dq_result_t want;
		if (!arst_n) begin
			head_slot = 0;
			held_count = 0;
			pending_results.delete();
			fail_count = 0;
			errors <= 0;
			outstanding <= 0;
		end else begin
			if (done) begin
				if (pending_results.size() == 0) begin
					fail_count++;
					$display("%0t: result word with none expected, %s %0h",
						$time, "expected nothing, actual status", status);
				end else begin
					want = pending_results.pop_front();
					if (status !== want.status) report("status", want.status, status);
					if (popped_value !== want.popped)
						report("popped_value", want.popped, popped_value);
					if (found !== want.found) report("found", want.found, found);
					if (match_count !== want.hit_count)
						report("match_count", want.hit_count, match_count);
					if (occupancy !== want.held) report("occupancy", want.held, occupancy);
				end
			end
			if (start && !busy) pending_results.push_back(apply_request(req_type, value));
			errors <= fail_count;
			outstanding <= pending_results.size();
		end
	end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Testbench top for the double-ended queue with search: clock, reset, stimulus and verdict.
module tb_top;

	// Number of real requests (codes 0 to 4) in the random part.
	localparam int RANDOM_WORDS = 1430;
	// Cycles without any handshake before the run is declared hung. The slowest word
	// is a full-queue search, and the longest wait between words is a long sender gap.
	localparam int IDLE_LIMIT = 1000;
	// Settling time after the last result, a little above the worst search latency.
	localparam int TAIL_CYCLES = 25;

	// Segment flavors of the random part.
	typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED, MODE_REPEAT} seg_mode_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              start = 1'b0;
	logic [dws_pkg::REQ_W-1:0]         req_type = dws_pkg::REQ_PUSH_BACK;
	logic signed [dws_pkg::DATA_W-1:0] value = '0;
	logic                              busy;
	logic                              done;
	logic [dws_pkg::STAT_W-1:0]        status;
	logic signed [dws_pkg::DATA_W-1:0] popped_value;
	logic                              found;
	logic [dws_pkg::OUT_W-1:0]         match_count;
	logic [dws_pkg::OUT_W-1:0]         occupancy;
	int                                errors;
	int                                outstanding;
	int                                idle_cycles = 0;

	// A few values that recur often, so that searches hit several entries and
	// the sign bit and the all-ones and all-zeros patterns are stored and found.
	logic [dws_pkg::DATA_W-1:0] hot_values [8] = '{32'h0000_0000, 32'h0000_0001,
		32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_FFFF, 32'hAAAA_AAAA,
		32'h5555_5555};

	always #5 clk = ~clk;

	deque_with_search_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.value        (value),
		.done         (done),
		.status       (status),
		.popped_value (popped_value),
		.found        (found),
		.match_count  (match_count),
		.occupancy    (occupancy)
	);

	dws_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.value        (value),
		.done         (done),
		.status       (status),
		.popped_value (popped_value),
		.found        (found),
		.match_count  (match_count),
		.occupancy    (occupancy),
		.errors       (errors),
		.outstanding  (outstanding)
	);

	// Hang detection: any accepted request or any result word restarts the count.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Sender gap: mostly back to back, sometimes a few cycles, rarely a long pause.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 19);
		if (roll < 12) return 0;
		if (roll < 18) return $urandom_range(1, 3);
		return $urandom_range(12, 40);
	endfunction

	// Holds the word on the ports until the block takes it. The busy read right after
	// the edge sees the value that the edge itself sampled. With no gap to follow,
	// start simply stays high for the next word.
	task automatic send_word(input dws_pkg::req_t kind,
			input logic [dws_pkg::DATA_W-1:0] operand, input bit quiet);
		int gap;
		start    <= 1'b1;
		req_type <= kind;
		value    <= operand;
		@(posedge clk);
		while (busy) @(posedge clk);
		gap = quiet ? 0 : pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops sending until every expected result word has come back. The count from the
	// checker is registered, so it already includes the word taken at the last edge.
	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Request mix per segment: fill segments mostly push, drain segments mostly pop,
	// so both the full and the empty refusal come up again and again.
	function automatic dws_pkg::req_t pick_request(input seg_mode_t mode);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll >= 97) return dws_pkg::req_t'($urandom_range(5, 7));
		case (mode)
			MODE_FILL, MODE_REPEAT: begin
				if (roll < 40) return dws_pkg::REQ_PUSH_BACK;
				if (roll < 75) return dws_pkg::REQ_PUSH_FRONT;
				if (roll < 87) return dws_pkg::REQ_SEARCH;
				if (roll < 93) return dws_pkg::REQ_POP_FRONT;
				return dws_pkg::REQ_POP_BACK;
			end
			MODE_DRAIN: begin
				if (roll < 10) return dws_pkg::REQ_PUSH_BACK;
				if (roll < 20) return dws_pkg::REQ_PUSH_FRONT;
				if (roll < 32) return dws_pkg::REQ_SEARCH;
				if (roll < 64) return dws_pkg::REQ_POP_FRONT;
				return dws_pkg::REQ_POP_BACK;
			end
			default: begin
				if (roll < 20) return dws_pkg::REQ_PUSH_BACK;
				if (roll < 40) return dws_pkg::REQ_PUSH_FRONT;
				if (roll < 70) return dws_pkg::REQ_SEARCH;
				if (roll < 83) return dws_pkg::REQ_POP_FRONT;
				return dws_pkg::REQ_POP_BACK;
			end
		endcase
	endfunction

	// Repeat segments lean hard on one value so that a search can count up to a
	// full queue of matches.
	function automatic logic [dws_pkg::DATA_W-1:0] pick_value(input seg_mode_t mode,
			input logic [dws_pkg::DATA_W-1:0] favorite);
		int roll;
		roll = $urandom_range(0, 9);
		if (mode == MODE_REPEAT && roll < 8) return favorite;
		if (roll < 4) return hot_values[$urandom_range(0, 7)];
		if (roll < 6) return favorite;
		return $urandom;
	endfunction

	initial begin
		int                         words_sent;
		int                         seg_len;
		bit                         quiet;
		seg_mode_t                  mode;
		dws_pkg::req_t              kind;
		logic [dws_pkg::DATA_W-1:0] favorite;

		words_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: refusals on an empty queue, a search with nothing held and the
		// unused codes, then a push at the front of an empty queue that must also be
		// reachable from the back, the value extremes, and a search with two hits.
		send_word(dws_pkg::REQ_POP_FRONT, 32'h1234_5678, 1'b0);
		send_word(dws_pkg::REQ_POP_BACK, 32'hFFFF_FFFF, 1'b0);
		send_word(dws_pkg::REQ_SEARCH, 32'h0000_0000, 1'b0);
		send_word(dws_pkg::req_t'(5), 32'h0000_0000, 1'b0);
		send_word(dws_pkg::REQ_PUSH_FRONT, 32'h7FFF_FFFF, 1'b0);
		send_word(dws_pkg::REQ_POP_BACK, 32'h0000_0000, 1'b0);
		send_word(dws_pkg::REQ_PUSH_BACK, 32'h8000_0000, 1'b0);
		send_word(dws_pkg::REQ_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0);
		send_word(dws_pkg::REQ_PUSH_BACK, 32'h8000_0000, 1'b0);
		send_word(dws_pkg::REQ_PUSH_BACK, 32'h0000_0000, 1'b0);
		send_word(dws_pkg::REQ_SEARCH, 32'h8000_0000, 1'b0);
		send_word(dws_pkg::REQ_SEARCH, 32'h7FFF_FFFF, 1'b0);
		send_word(dws_pkg::req_t'(6), 32'hFFFF_FFFF, 1'b0);
		send_word(dws_pkg::req_t'(7), 32'h8000_0000, 1'b0);
		send_word(dws_pkg::REQ_POP_FRONT, 32'h0000_0000, 1'b0);
		send_word(dws_pkg::REQ_POP_BACK, 32'h0000_0000, 1'b0);
		send_word(dws_pkg::REQ_POP_BACK, 32'h0000_0000, 1'b0);
		send_word(dws_pkg::REQ_POP_FRONT, 32'h0000_0000, 1'b0);
		send_word(dws_pkg::REQ_POP_FRONT, 32'h0000_0000, 1'b0);
		// At least one full stop with nothing in flight.
		drain_results();

		// Random part in segments of one flavor each; some segments run without gaps.
		while (words_sent < RANDOM_WORDS) begin
			mode = seg_mode_t'($urandom_range(0, 3));
			seg_len = $urandom_range(8, 40);
			quiet = ($urandom_range(0, 3) == 0);
			favorite = ($urandom_range(0, 1) == 0) ? hot_values[$urandom_range(0, 7)]
			                                       : $urandom;
			for (int n = 0; n < seg_len; n++) begin
				kind = pick_request(mode);
				send_word(kind, pick_value(mode, favorite), quiet);
				if (kind <= dws_pkg::REQ_SEARCH) words_sent++;
			end
			if ($urandom_range(0, 3) == 0) drain_results();
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
